### design/kls_pkg.sv
// Package for the k-th largest stream tracker.
// Key and field widths, sequencer states and the structs shared between modules.
// No dependencies.
package kls_pkg;

	localparam int KLS_MAX_K = 64;
	localparam int KEY_W = 32;
	localparam int HS_W = 7;
	localparam logic [KEY_W-1:0] SIGN_FLIP = 32'h8000_0000;
	localparam logic [KEY_W-1:0] EMPTY_KEY = '0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_DONE
	} kls_state_t;

	typedef struct packed {
		logic clr;
		logic res_free;
	} kls_ctl_t;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  kth;
	} kls_res_t;

endpackage

### design/kls_item_if.sv
// Input channel of the tracker: one word per offered value.
// Depends on kls_pkg.
interface kls_item_if import kls_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              action;
	logic signed [KEY_W-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

### design/kls_result_if.sv
// Result channel of the tracker: one word per add action.
// Depends on kls_pkg.
interface kls_result_if import kls_pkg::*; ();
	logic              valid;
	logic              ready;
	logic signed [KEY_W-1:0] kth_largest;

	modport source (output valid, output kth_largest, input ready);
	modport sink (input valid, input kth_largest, output ready);
endinterface

### design/kls_cfg_if.sv
// Configuration write channel: carries the heap_size register word.
// Depends on kls_pkg.
interface kls_cfg_if import kls_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [HS_W-1:0]   heap_size;

	modport source (output valid, output heap_size, input ready);
	modport sink (input valid, input heap_size, output ready);
endinterface

### design/kth_largest_stream_tracker.sv
// K-th largest tracker: keeps the k largest signed values in a min-heap held in a RAM of
// MAX_K words and reports the heap root for each add word. An item whose value is below
// the root leaves the heap as it is. Otherwise the value replaces the root and moves down
// one heap level at a time until it stops above its children or reaches a leaf; the
// sift-down loop does one RAM read and one compare per level. After reset and after each
// heap_size write a clear sweep over all MAX_K words runs before the next item is taken.
// A finished result waits in an output register; an add word that finishes while that
// register is still full stalls until it drains.
module kth_largest_stream_tracker import kls_pkg::*; #(
	parameter int MAX_K = KLS_MAX_K
) (
	input  logic          clk,
	input  logic          arst_n,
	kls_cfg_if.sink       cfg,
	kls_item_if.sink      item,
	kls_result_if.source  result
);

	localparam int CW = $clog2(MAX_K + 1);

	logic [CW-1:0]     size_q;
	logic              out_valid_q;
	logic [KEY_W-1:0]  out_data_q;
	kls_ctl_t          ctl;
	kls_res_t          res;

	assign cfg.ready          = 1'b1;
	assign ctl.clr            = cfg.valid;
	assign ctl.res_free       = !out_valid_q || result.ready;
	assign result.valid       = out_valid_q;
	assign result.kth_largest = out_data_q;

	kls_sift #(.MAX_K(MAX_K)) u_sift (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.size   (size_q),
		.ctl    (ctl),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= CW'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.heap_size == '0) begin
					size_q <= CW'(1);
				end else if (32'(cfg.heap_size) > 32'(MAX_K)) begin
					size_q <= CW'(MAX_K);
				end else begin
					size_q <= CW'(cfg.heap_size);
				end
			end
			if (res.valid) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_data_q <= res.kth;
		end
	end

endmodule

### design/kls_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module kls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### design/kls_sift.sv
// Heap sequencer: clear sweep, root test and sift-down over the heap RAM.
// Depends on kls_pkg, kls_item_if and kls_ram.
module kls_sift import kls_pkg::*; #(
	parameter int MAX_K = KLS_MAX_K,
	localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1,
	localparam int CW = $clog2(MAX_K + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	kls_item_if.sink      item,
	input  logic [CW-1:0] size,
	input  kls_ctl_t      ctl,
	output kls_res_t      res
);

	kls_state_t        state_q, state_d;
	logic [KEY_W-1:0]  key_q, root_q;
	logic              act_q, right_q;
	logic [AW-1:0]     pos_q, c_q, clr_q;

	logic [AW+1:0]     c_full, c_right;
	logic              has_child, has_right, pick_b, last_clr;
	logic [KEY_W-1:0]  rd_a, rd_b, ckey, in_key;
	logic [AW-1:0]     cidx, raddr_a, raddr_b, waddr;
	logic              we;
	logic [KEY_W-1:0]  wdata;

	assign c_full    = {1'b0, pos_q, 1'b1};
	assign c_right   = c_full + (AW+2)'(1);
	assign has_child = 32'(c_full) < 32'(size);
	assign has_right = 32'(c_right) < 32'(size);
	assign raddr_a   = has_child ? c_full[AW-1:0] : '0;
	assign raddr_b   = has_right ? c_right[AW-1:0] : raddr_a;
	assign pick_b    = right_q && (rd_b < rd_a);
	assign ckey      = pick_b ? rd_b : rd_a;
	assign cidx      = pick_b ? c_q + AW'(1) : c_q;
	assign in_key    = KEY_W'(item.value) ^ SIGN_FLIP;
	assign last_clr  = 32'(clr_q) == 32'(MAX_K - 1);
	assign item.ready = (state_q == ST_IDLE);

	kls_ram #(.WIDTH(KEY_W), .DEPTH(MAX_K)) u_heap (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_comb begin
		state_d   = state_q;
		we        = 1'b0;
		waddr     = pos_q;
		wdata     = key_q;
		res.valid = 1'b0;
		res.kth   = root_q ^ SIGN_FLIP;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = EMPTY_KEY;
				if (last_clr) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item.valid) begin
					state_d = (in_key >= root_q) ? ST_READ : ST_DONE;
				end
			end
			ST_READ: begin
				if (has_child) begin
					state_d = ST_CMP;
				end else begin
					we      = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_CMP: begin
				we = 1'b1;
				if (ckey < key_q) begin
					wdata   = ckey;
					state_d = ST_READ;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (act_q) begin
					state_d = ST_IDLE;
				end else if (ctl.res_free) begin
					res.valid = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (ctl.clr) begin
			state_d = ST_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			root_q  <= EMPTY_KEY;
		end else begin
			state_q <= state_d;
			if (ctl.clr) begin
				clr_q  <= '0;
				root_q <= EMPTY_KEY;
			end else begin
				if (state_q == ST_CLEAR) begin
					clr_q <= clr_q + AW'(1);
				end
				if (we && waddr == '0) begin
					root_q <= wdata;
				end
			end
		end
	end

	// heap walk registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item.valid) begin
			key_q <= in_key;
			act_q <= item.action;
			pos_q <= '0;
		end
		if (state_q == ST_READ) begin
			c_q     <= c_full[AW-1:0];
			right_q <= has_right;
		end
		if (state_q == ST_CMP && ckey < key_q) begin
			pos_q <= cidx;
		end
	end

endmodule
